/* sv/tftp_transfer_engine_defines.svh */
// Assertion macros shared by the transfer engine.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TFTP_TRANSFER_ENGINE_DEFINES_SVH
`define TFTP_TRANSFER_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    localparam int DEF_BLOCK_BYTES = 512;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [7:0] OPC_DATA  = 8'd3;
    localparam logic [7:0] OPC_ACK   = 8'd4;
    localparam logic [7:0] OPC_ERROR = 8'd5;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_RRQ    = 3'd1,
        K_WRQ    = 3'd2,
        K_DATA   = 3'd3,
        K_ACK    = 3'd4,
        K_RESEND = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_DONE       = 3'd1,
        ST_SERVER_ERR = 3'd2,
        ST_UNEXPECTED = 3'd3,
        ST_TIMEOUT    = 3'd4
    } t_status;

    // Event class decided by the front end.
    typedef enum logic [2:0] {
        CL_START   = 3'd0,
        CL_IGNORE  = 3'd1,
        CL_TIMEOUT = 3'd2,
        CL_ERROR   = 3'd3,
        CL_DATA    = 3'd4,
        CL_ACK     = 3'd5,
        CL_OTHER   = 3'd6
    } t_class;

    typedef struct packed {
        t_class      cls;
        logic [15:0] blk;
        logic        full_pkt;   // received length equals a full DATA packet
        logic [9:0]  data_len;   // saturated length of the next DATA block
        logic        final_blk;  // that block is shorter than a full block
    } t_entry;

    typedef struct packed {
        logic       write_mode;
        logic [3:0] read_miss_limit;
        logic [3:0] write_miss_limit;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] block;
        logic [9:0]  len;
        logic        write_payload;
        logic        latch_peer;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

/* sv/tte_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_front
    import tte_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_pkt_opcode,
    input  wire logic [15:0] i_pkt_block,
    input  wire logic [9:0]  i_pkt_len,
    input  wire logic [9:0]  i_next_len,
    input  wire logic        i_q_ready,
    output logic             o_ready,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam logic [16:0] BB      = 17'(BLOCK_BYTES);
    localparam logic [16:0] BB_FULL = 17'(BLOCK_BYTES + 4);

    t_class     cls;
    logic [9:0] sat_len;

    always_comb begin
        case (i_op)
            OP_START:   cls = CL_START;
            OP_TIMEOUT: cls = CL_TIMEOUT;
            OP_PACKET: begin
                case (i_pkt_opcode)
                    OPC_ERROR: cls = CL_ERROR;
                    OPC_DATA:  cls = CL_DATA;
                    OPC_ACK:   cls = CL_ACK;
                    default:   cls = CL_OTHER;
                endcase
            end
            default:    cls = CL_IGNORE;
        endcase
    end

    // A requested length above one block is clipped to the block size.
    assign sat_len = ({7'd0, i_next_len} > BB) ? BB[9:0] : i_next_len;

    assign o_entry.cls       = cls;
    assign o_entry.blk       = i_pkt_block;
    assign o_entry.full_pkt  = ({7'd0, i_pkt_len} == BB_FULL);
    assign o_entry.data_len  = sat_len;
    assign o_entry.final_blk = ({7'd0, sat_len} < BB);

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

endmodule

`default_nettype wire

/* sv/tte_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_queue
    import tte_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    input  wire logic   i_pop,
    output logic        o_valid,
    output logic        o_ready,
    output t_entry      o_entry
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? wrap_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? wrap_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* sv/tte_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tte_back
    import tte_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  wire logic   i_q_valid,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_block, n_block;
    logic [3:0]  r_miss, n_miss;
    logic        r_final, n_final;
    t_kind       r_last_kind, n_last_kind;
    logic [9:0]  r_last_len, n_last_len;
    logic        r_out_valid;
    t_result     r_res, res;

    logic        is_read, is_write, busy;
    logic        blk_match, limit_hit;
    logic [3:0]  limit;
    logic [15:0] blk_inc, blk_dec, resend_blk;

    assign o_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign is_read   = (r_phase == PH_READ);
    assign is_write  = (r_phase == PH_WRITE);
    assign busy      = is_read || is_write;
    assign blk_match = (i_entry.blk == r_block);
    assign limit     = is_write ? i_cfg.write_miss_limit : i_cfg.read_miss_limit;
    assign limit_hit = (r_miss >= limit);
    assign blk_inc   = r_block + 16'd1;
    assign blk_dec   = r_block - 16'd1;
    assign resend_blk = ((r_last_kind == K_RRQ) || (r_last_kind == K_WRQ)) ? 16'd0 :
                        (is_write ? r_block : blk_dec);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            case (i_entry.cls)
                CL_START:   n_phase = i_cfg.write_mode ? PH_WRITE : PH_READ;
                CL_IGNORE:  n_phase = r_phase;
                CL_TIMEOUT: if (busy && limit_hit) n_phase = PH_IDLE;
                CL_ERROR:   n_phase = PH_IDLE;
                CL_DATA: begin
                    if (is_write || (is_read && blk_match && !i_entry.full_pkt)) begin
                        n_phase = PH_IDLE;
                    end
                end
                CL_ACK: begin
                    if (is_read || (is_write && blk_match && r_final)) begin
                        n_phase = PH_IDLE;
                    end
                end
                CL_OTHER:   n_phase = PH_IDLE;
                default:    n_phase = r_phase;
            endcase
        end
    end

    // Result and counter updates.
    always_comb begin
        n_block     = r_block;
        n_miss      = r_miss;
        n_final     = r_final;
        n_last_kind = r_last_kind;
        n_last_len  = r_last_len;
        res         = '{kind: K_NONE, block: 16'd0, len: 10'd0, write_payload: 1'b0,
                        latch_peer: 1'b0, status: ST_BUSY};
        if (o_pop) begin
            case (i_entry.cls)
                CL_START: begin
                    n_block     = i_cfg.write_mode ? 16'd0 : 16'd1;
                    n_miss      = 4'd0;
                    n_final     = 1'b0;
                    n_last_kind = i_cfg.write_mode ? K_WRQ : K_RRQ;
                    n_last_len  = 10'd0;
                    res.kind    = n_last_kind;
                end
                CL_IGNORE: begin
                end
                CL_TIMEOUT: begin
                    if (busy) begin
                        if (limit_hit) begin
                            res.status = ST_TIMEOUT;
                        end else begin
                            n_miss    = r_miss + 4'd1;
                            res.kind  = K_RESEND;
                            res.block = resend_blk;
                            res.len   = r_last_len;
                        end
                    end
                end
                CL_ERROR: begin
                    if (busy) begin
                        n_miss     = 4'd0;
                        res.status = ST_SERVER_ERR;
                    end
                end
                CL_DATA: begin
                    if (busy) begin
                        n_miss = 4'd0;
                    end
                    if (is_write) begin
                        res.status = ST_UNEXPECTED;
                    end else if (is_read && blk_match) begin
                        n_block           = blk_inc;
                        n_last_kind       = K_ACK;
                        n_last_len        = 10'd0;
                        res.kind          = K_ACK;
                        res.block         = r_block;
                        res.write_payload = 1'b1;
                        res.latch_peer    = 1'b1;
                        res.status        = i_entry.full_pkt ? ST_BUSY : ST_DONE;
                    end
                end
                CL_ACK: begin
                    if (busy) begin
                        n_miss = 4'd0;
                    end
                    if (is_read) begin
                        res.status = ST_UNEXPECTED;
                    end else if (is_write && blk_match) begin
                        if (r_final) begin
                            res.status = ST_DONE;
                        end else begin
                            n_block        = blk_inc;
                            n_final        = i_entry.final_blk;
                            n_last_kind    = K_DATA;
                            n_last_len     = i_entry.data_len;
                            res.kind       = K_DATA;
                            res.block      = blk_inc;
                            res.len        = i_entry.data_len;
                            res.latch_peer = 1'b1;
                        end
                    end
                end
                CL_OTHER: begin
                    if (busy) begin
                        n_miss     = 4'd0;
                        res.status = ST_UNEXPECTED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_block     <= 16'd0;
            r_miss      <= 4'd0;
            r_final     <= 1'b0;
            r_last_kind <= K_NONE;
            r_last_len  <= 10'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_block     <= n_block;
            r_miss      <= n_miss;
            r_final     <= n_final;
            r_last_kind <= n_last_kind;
            r_last_len  <= n_last_len;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* sv/tftp_transfer_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                    Payload
// event     in         i_in_valid / o_in_ready      op, pkt_opcode, pkt_block, pkt_len, next_len
// result    out        o_out_valid / i_out_ready    send_kind, send_block, send_len,
//                                                   write_payload, latch_peer, status
// config    in         i_cfg_wr_en (no wait)        i_cfg_index, i_cfg_data
//
// One event is taken every cycle and one result leaves every cycle while i_out_ready
// stays high; the back end's state update sets that rate. A request passes through the
// queue, and its result through the output register, before the result is presented.
// Reset is synchronous and active low; it clears the transfer state, the queue and the
// output register, and loads the configuration defaults.
// A stalled result holds the output register; the two-entry queue keeps taking
// requests until it fills, then o_in_ready falls.

module tftp_transfer_engine
    import tte_pkg::*;
#(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    // Event channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_pkt_opcode,
    input  wire logic [15:0] i_pkt_block,
    input  wire logic [9:0]  i_pkt_len,
    input  wire logic [9:0]  i_next_len,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_send_kind,
    output logic [15:0]      o_send_block,
    output logic [9:0]       o_send_len,
    output logic             o_write_payload,
    output logic             o_latch_peer,
    output logic [2:0]       o_status
);

`include "tftp_transfer_engine_defines.svh"

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_WRITE_MODE  = 2'd0;
    localparam logic [1:0] CFG_READ_MISS   = 2'd1;
    localparam logic [1:0] CFG_WRITE_MISS  = 2'd2;
    localparam logic [3:0] RST_READ_MISS   = 4'd5;
    localparam logic [3:0] RST_WRITE_MISS  = 4'd3;

    t_cfg    r_cfg;
    t_entry  front_entry, q_entry;
    logic    push, q_ready, q_valid, pop;
    t_result res;

    // Configuration registers, read directly by the back end. The user writes them only
    // while the engine is idle; the block does not enforce it. An index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_mode       <= 1'b0;
            r_cfg.read_miss_limit  <= RST_READ_MISS;
            r_cfg.write_miss_limit <= RST_WRITE_MISS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WRITE_MODE: r_cfg.write_mode       <= i_cfg_data[0];
                CFG_READ_MISS:  r_cfg.read_miss_limit  <= i_cfg_data;
                CFG_WRITE_MISS: r_cfg.write_miss_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end sorts each request into an event class and works out the
    // length checks that do not depend on transfer state.
    tte_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .i_valid      (i_in_valid),
        .i_op         (i_op),
        .i_pkt_opcode (i_pkt_opcode),
        .i_pkt_block  (i_pkt_block),
        .i_pkt_len    (i_pkt_len),
        .i_next_len   (i_next_len),
        .i_q_ready    (q_ready),
        .o_ready      (o_in_ready),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    // The queue decouples intake from the back end so that a stalled result
    // does not stop requests from being taken at once.
    tte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ready (q_ready),
        .o_entry (q_entry)
    );

    // The back end holds the transfer state: phase, block and miss counters, and
    // the last packet sent for resends. It retires one event per cycle into the
    // output register while that register is not stalled.
    tte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_send_kind     = res.kind;
    assign o_send_block    = res.block;
    assign o_send_len      = res.len;
    assign o_write_payload = res.write_payload;
    assign o_latch_peer    = res.latch_peer;
    assign o_status        = res.status;

    // The queue can only be full while the output register is stalled.
    `TTE_ASSERT_IMP(a_full_means_stalled, !o_in_ready, o_out_valid, "queue full without stall")
    // Once a stalled result is taken, the back end drains one entry, freeing a slot.
    `TTE_ASSERT_NXT(a_drain_frees_slot, o_out_valid && i_out_ready && !o_in_ready, o_in_ready, "no slot freed after drain")
    // Every ACK sent stores the received payload and latches the peer.
    `TTE_ASSERT_IMP(a_ack_stores, o_out_valid && (o_send_kind == K_ACK), o_write_payload && o_latch_peer, "ACK without store")
    // A transfer ends only with nothing sent or with the final ACK.
    `TTE_ASSERT_IMP(a_end_kind, o_out_valid && (o_status != ST_BUSY), (o_send_kind == K_NONE) || (o_send_kind == K_ACK), "bad kind at transfer end")

endmodule

`default_nettype wire
